[hdl/swm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the star wildcard matcher
// Request codes, character width, the star code point and the control
// structures passed between the top level and the matching core.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int CHAR_W = 21;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 21'd42;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    // One request handed to the core in the cycle it is executed.
    typedef struct packed {
        logic              step;
        t_action           action;
        logic [CHAR_W-1:0] character;
    } t_core_req;

    // Verdict for the text seen so far, valid in any cycle.
    typedef struct packed {
        logic matched;
        logic overflow;
    } t_core_rsp;

endpackage

[hdl/swm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_if: request and result channels of the star wildcard matcher
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface swm_in_if
    import swm_pkg::*;
();
    logic              valid;
    logic              ready;
    t_action           action;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output action, output character, input ready);
    modport sink   (input valid, input action, input character, output ready);
endinterface

interface swm_out_if
    import swm_pkg::*;
();
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink   (input valid, input matched, input overflow, output ready);
endinterface

[hdl/swm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_core: pattern store and bit-parallel NFA
// Holds the pattern, its star mask and the active position vector; applies
// one request per cycle when stepped. Star runs are closed with a single add.
// ----------------------------------------------------------------------------
module swm_core
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_req i_req,
    output t_core_rsp o_rsp
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [CHAR_W-1:0]    r_store [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_star, n_star;
    logic [PATTERN_MAX-1:0] r_live, n_live;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_ovf, n_ovf;
    logic [PATTERN_MAX:0] r_act, n_act;

    logic                 room;
    logic [IDX_W-1:0]     wr_idx;
    logic [PATTERN_MAX:0] adv;
    logic [PATTERN_MAX:0] seed;
    logic [PATTERN_MAX:0] star_ext;
    logic [PATTERN_MAX:0] gen;
    logic [PATTERN_MAX:0] carry_sum;

    assign room   = (r_len < LEN_W'(PATTERN_MAX));
    assign wr_idx = r_len[IDX_W-1:0];

    // One text character applied to every active position in parallel.
    always_comb begin
        adv = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (r_act[i] && r_star[i]) begin
                adv[i] = 1'b1;
            end
            if (r_act[i] && r_live[i] && !r_star[i] && (r_store[i] == i_req.character)) begin
                adv[i+1] = 1'b1;
            end
        end
    end

    always_comb begin
        n_star = r_star;
        n_live = r_live;
        n_len  = r_len;
        n_ovf  = r_ovf;
        seed   = (PATTERN_MAX + 1)'(1);
        unique case (i_req.action)
            ACT_CLEAR: begin
                n_star = '0;
                n_live = '0;
                n_len  = '0;
                n_ovf  = 1'b0;
            end
            ACT_APPEND: begin
                if (room) begin
                    n_star[wr_idx] = (i_req.character == STAR_CHAR);
                    n_live[wr_idx] = 1'b1;
                    n_len          = r_len + LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            ACT_TEXT: begin
                seed = adv;
            end
            ACT_END: begin
            end
            default: begin
            end
        endcase
    end

    // Star closure: the carries of (seed & star) + star enter exactly the
    // positions reached from an active star through a run of stars.
    assign star_ext  = {1'b0, n_star};
    assign gen       = seed & star_ext;
    assign carry_sum = (gen + star_ext) ^ star_ext ^ gen;
    assign n_act     = seed | carry_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star <= '0;
            r_live <= '0;
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_act  <= (PATTERN_MAX + 1)'(1);
        end else if (i_req.step) begin
            r_star <= n_star;
            r_live <= n_live;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.step && (i_req.action == ACT_APPEND) && room) begin
            r_store[wr_idx] <= i_req.character;
        end
    end

    assign o_rsp.matched  = r_act[r_len] && !r_ovf;
    assign o_rsp.overflow = r_ovf;

endmodule

[hdl/star_wildcard_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_wildcard_matcher: whole-string glob match with '*' as the only wildcard
// Loads a pattern one character per request, then matches streamed text
// characters against it and reports one verdict per end-of-text request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle for all four request kinds
// (clear pattern, append pattern character, text character and end of
// text) unless a held end-of-text request stalls it. A request is captured
// in an input register and executed from there, where a single combinational
// pass compares the character against every stored pattern position at once
// and closes runs of stars with one carry-propagating add. An end-of-text
// request produces one result, which sits in an output register until it
// is taken. While that result waits, further requests of other kinds still
// flow; only a second end-of-text request is held in the input register
// until the output register frees up. A pattern holds up to PATTERN_MAX
// characters (code point 42 is the star); appending beyond that sets the
// overflow flag, which forces every verdict to no match until the next
// clear. The pattern is kept across strings, so a new text needs no reload.
// ----------------------------------------------------------------------------
module star_wildcard_matcher
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    swm_in_if.sink           i_in,
    swm_out_if.source        o_out
);

    // Input register: one request waiting to be executed.
    logic              r_in_valid;
    t_action           r_in_action;
    logic [CHAR_W-1:0] r_in_char;

    // Output register: one verdict waiting to be taken.
    logic              r_out_valid;
    logic              r_out_matched;
    logic              r_out_overflow;

    logic      proceed;
    t_core_req core_req;
    t_core_rsp core_rsp;

    // The held request can execute unless it is an end of text and the
    // previous verdict is still in the output register and not being taken.
    assign proceed = !((r_in_action == ACT_END) && r_out_valid && !o_out.ready);

    // The input register frees up whenever its request executes.
    assign i_in.ready = !r_in_valid || proceed;

    assign core_req.step      = r_in_valid && proceed;
    assign core_req.action    = r_in_action;
    assign core_req.character = r_in_char;

    swm_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_action <= i_in.action;
            r_in_char   <= i_in.character;
        end
    end

    // The verdict reflects the active set before the end-of-text restart,
    // which the core applies in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_req.step && (r_in_action == ACT_END)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_req.step && (r_in_action == ACT_END)) begin
            r_out_matched  <= core_rsp.matched;
            r_out_overflow <= core_rsp.overflow;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.matched  = r_out_matched;
    assign o_out.overflow = r_out_overflow;

endmodule
